// File: rtl/evr_pkg.sv
// ----------------------------------------------------------------------------
// evr_pkg
// Shared types and constants for the Euler Z-Y-X vector rotation block.
// ----------------------------------------------------------------------------
package evr_pkg;

  // coordinate width, signed Q16.16
  localparam int unsigned CoordW = 32;

  // pi/2 in Q30, used when the sine table is built
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Taylor series divisors (2k)(2k+1), k = 1..39
  localparam longint unsigned TAYLOR_DIV [1:39] = '{
    64'd6,    64'd20,   64'd42,   64'd72,   64'd110,  64'd156,  64'd210,  64'd272,
    64'd342,  64'd420,  64'd506,  64'd600,  64'd702,  64'd812,  64'd930,  64'd1056,
    64'd1190, 64'd1332, 64'd1482, 64'd1640, 64'd1806, 64'd1980, 64'd2162, 64'd2352,
    64'd2550, 64'd2756, 64'd2970, 64'd3192, 64'd3422, 64'd3660, 64'd3906, 64'd4160,
    64'd4422, 64'd4692, 64'd4970, 64'd5256, 64'd5550, 64'd5852, 64'd6162
  };

  // one input transaction
  typedef struct packed {
    logic signed [CoordW-1:0] vec_x;
    logic signed [CoordW-1:0] vec_y;
    logic signed [CoordW-1:0] vec_z;
    logic signed [15:0]       angle_yaw;
    logic signed [15:0]       angle_pitch;
    logic signed [15:0]       angle_roll;
  } evr_in_t;

  // one output transaction
  typedef struct packed {
    logic signed [CoordW-1:0] out_x;
    logic signed [CoordW-1:0] out_y;
    logic signed [CoordW-1:0] out_z;
    logic                     saturated;
  } evr_out_t;

endpackage

// File: rtl/euler_vector_rotation.sv
// ----------------------------------------------------------------------------
// euler_vector_rotation
// Rotates a Q16.16 vector by R = Rz(yaw) * Ry(pitch) * Rx(roll), with
// saturation of each component and a flag when any component clips.
// ----------------------------------------------------------------------------
// A new transaction can be taken in every clock cycle unless an output
// stall backs up. The seven register stages are: quarter-wave sine ROM
// read (TRIG_TABLE_DEPTH+1 entries, six lookups), sign fix and pairwise
// trig products, triple products, Q30 matrix rounding, the nine 32x32
// coordinate products, product rounding, and the final sum with
// saturation. Each stage holds its own valid bit and moves on whenever the
// stage after it is empty or moving, so bubbles close up under a stall.
module euler_vector_rotation #(
  parameter int unsigned TRIG_TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  evr_pkg::evr_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output evr_pkg::evr_out_t out_data_o
);
  import evr_pkg::*;

  localparam int unsigned IdxW   = $clog2(TRIG_TABLE_DEPTH + 1);
  localparam int unsigned NStage = 7;
  localparam logic [IdxW+13:0] DepthW = (IdxW+14)'(TRIG_TABLE_DEPTH);
  localparam logic [IdxW-1:0]  DepthI = IdxW'(TRIG_TABLE_DEPTH);

  // sine table entry i in Q1.15, built at elaboration
  function automatic logic [14:0] sin_entry(input int unsigned i);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    longint          q;
    int              k;
    x    = (64'(i) * HALF_PI_Q30 + 64'(TRIG_TABLE_DEPTH / 2)) / 64'(TRIG_TABLE_DEPTH);
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = $signed(x);
    for (k = 1; term != 0 && k < 40; k++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[k];
      if (k[0]) sum = sum - $signed(term);
      else      sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    q = $signed(($unsigned(sum) + 64'd16384) >> 15);
    if (q > 32767) q = 32767;
    return q[14:0];
  endfunction

  // quadrant decode: {negate, table index}
  function automatic logic [IdxW:0] ang_decode(input logic [15:0] ang);
    logic [IdxW+13:0] prod;
    logic [IdxW-1:0]  idx;
    prod = (IdxW+14)'(ang[13:0]) * DepthW;
    idx  = prod[IdxW+13:14];
    return {ang[15], (ang[14] ? DepthI - idx : idx)};
  endfunction

  // apply sign to a table magnitude
  function automatic logic signed [15:0] sgn(input logic neg, input logic [14:0] mag);
    logic signed [15:0] m;
    m = $signed({1'b0, mag});
    return neg ? -m : m;
  endfunction

  // Q45 to Q30, round half up, clamp to +-2^30
  function automatic logic signed [31:0] round45(input logic signed [48:0] v);
    logic signed [48:0] r;
    r = (v + 49'sd16384) >>> 15;
    if (r > 49'sd1073741824)  r = 49'sd1073741824;
    if (r < -49'sd1073741824) r = -49'sd1073741824;
    return r[31:0];
  endfunction

  // constant sine rom
  logic [14:0] sin_rom [TRIG_TABLE_DEPTH+1];
  for (genvar g = 0; g <= TRIG_TABLE_DEPTH; g++) begin : g_rom
    assign sin_rom[g] = sin_entry(g);
  end

  // stage valid chain and per-stage advance
  logic [NStage:1] valid_q;
  logic [NStage:1] ready;

  always_comb begin
    ready[NStage] = !valid_q[NStage] || !out_stall_i;
    for (int k = NStage - 1; k >= 1; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  assign in_stall_o  = !ready[1];
  assign out_valid_o = valid_q[NStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[1]) valid_q[1] <= in_valid_i;
      for (int k = 2; k <= NStage; k++) begin
        if (ready[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage 1: angle decode and rom read
  logic [IdxW:0] dec_sy, dec_cy, dec_sp, dec_cp, dec_sr, dec_cr;
  assign dec_sy = ang_decode(in_data_i.angle_yaw);
  assign dec_cy = ang_decode(in_data_i.angle_yaw + 16'd16384);
  assign dec_sp = ang_decode(in_data_i.angle_pitch);
  assign dec_cp = ang_decode(in_data_i.angle_pitch + 16'd16384);
  assign dec_sr = ang_decode(in_data_i.angle_roll);
  assign dec_cr = ang_decode(in_data_i.angle_roll + 16'd16384);

  logic signed [CoordW-1:0] v1x_q, v1y_q, v1z_q;
  logic [14:0] m_sy_q, m_cy_q, m_sp_q, m_cp_q, m_sr_q, m_cr_q;
  logic [5:0]  neg_q;

  always_ff @(posedge clk_i) begin
    if (ready[1]) begin
      v1x_q  <= in_data_i.vec_x;
      v1y_q  <= in_data_i.vec_y;
      v1z_q  <= in_data_i.vec_z;
      m_sy_q <= sin_rom[dec_sy[IdxW-1:0]];
      m_cy_q <= sin_rom[dec_cy[IdxW-1:0]];
      m_sp_q <= sin_rom[dec_sp[IdxW-1:0]];
      m_cp_q <= sin_rom[dec_cp[IdxW-1:0]];
      m_sr_q <= sin_rom[dec_sr[IdxW-1:0]];
      m_cr_q <= sin_rom[dec_cr[IdxW-1:0]];
      neg_q  <= {dec_sy[IdxW], dec_cy[IdxW], dec_sp[IdxW],
                 dec_cp[IdxW], dec_sr[IdxW], dec_cr[IdxW]};
    end
  end

  // stage 2: signs and pairwise products
  logic signed [15:0] sy, cy, sp, cp, sr, cr;
  assign sy = sgn(neg_q[5], m_sy_q);
  assign cy = sgn(neg_q[4], m_cy_q);
  assign sp = sgn(neg_q[3], m_sp_q);
  assign cp = sgn(neg_q[2], m_cp_q);
  assign sr = sgn(neg_q[1], m_sr_q);
  assign cr = sgn(neg_q[0], m_cr_q);

  logic signed [CoordW-1:0] v2x_q, v2y_q, v2z_q;
  logic signed [31:0] cysp_q, sysp_q, cycp_q, sycp_q, cpsr_q, cpcr_q;
  logic signed [31:0] sycr_q, sysr_q, cycr_q, cysr_q;
  logic signed [15:0] sr2_q, cr2_q, sp2_q;

  always_ff @(posedge clk_i) begin
    if (ready[2]) begin
      v2x_q  <= v1x_q;
      v2y_q  <= v1y_q;
      v2z_q  <= v1z_q;
      cysp_q <= cy * sp;
      sysp_q <= sy * sp;
      cycp_q <= cy * cp;
      sycp_q <= sy * cp;
      cpsr_q <= cp * sr;
      cpcr_q <= cp * cr;
      sycr_q <= sy * cr;
      sysr_q <= sy * sr;
      cycr_q <= cy * cr;
      cysr_q <= cy * sr;
      sr2_q  <= sr;
      cr2_q  <= cr;
      sp2_q  <= sp;
    end
  end

  // stage 3: triple products and the exact Q30 entries
  logic signed [CoordW-1:0] v3x_q, v3y_q, v3z_q;
  logic signed [47:0] t01_q, t02_q, t11_q, t12_q;
  logic signed [31:0] c01_q, c02_q, c11_q, c12_q;
  logic signed [31:0] m3_00_q, m3_10_q, m3_20_q, m3_21_q, m3_22_q;

  always_ff @(posedge clk_i) begin
    if (ready[3]) begin
      v3x_q   <= v2x_q;
      v3y_q   <= v2y_q;
      v3z_q   <= v2z_q;
      t01_q   <= 48'(cysp_q) * 48'(sr2_q);
      t02_q   <= 48'(cysp_q) * 48'(cr2_q);
      t11_q   <= 48'(sysp_q) * 48'(sr2_q);
      t12_q   <= 48'(sysp_q) * 48'(cr2_q);
      c01_q   <= sycr_q;
      c02_q   <= sysr_q;
      c11_q   <= cycr_q;
      c12_q   <= cysr_q;
      m3_00_q <= cycp_q;
      m3_10_q <= sycp_q;
      m3_20_q <= -(32'(sp2_q) <<< 15);
      m3_21_q <= cpsr_q;
      m3_22_q <= cpcr_q;
    end
  end

  // stage 4: combine Q45 sums and round to Q30
  logic signed [CoordW-1:0] v4x_q, v4y_q, v4z_q;
  logic signed [31:0] mat_q [9];

  always_ff @(posedge clk_i) begin
    if (ready[4]) begin
      v4x_q    <= v3x_q;
      v4y_q    <= v3y_q;
      v4z_q    <= v3z_q;
      mat_q[0] <= m3_00_q;
      mat_q[1] <= round45(49'(t01_q) - (49'(c01_q) <<< 15));
      mat_q[2] <= round45(49'(t02_q) + (49'(c02_q) <<< 15));
      mat_q[3] <= m3_10_q;
      mat_q[4] <= round45(49'(t11_q) + (49'(c11_q) <<< 15));
      mat_q[5] <= round45(49'(t12_q) - (49'(c12_q) <<< 15));
      mat_q[6] <= m3_20_q;
      mat_q[7] <= m3_21_q;
      mat_q[8] <= m3_22_q;
    end
  end

  // stage 5: coordinate times matrix entry
  logic signed [63:0] prod_q [9];

  always_ff @(posedge clk_i) begin
    if (ready[5]) begin
      for (int r = 0; r < 3; r++) begin
        prod_q[3*r]   <= 64'(v4x_q) * 64'(mat_q[3*r]);
        prod_q[3*r+1] <= 64'(v4y_q) * 64'(mat_q[3*r+1]);
        prod_q[3*r+2] <= 64'(v4z_q) * 64'(mat_q[3*r+2]);
      end
    end
  end

  // stage 6: round each product half up to Q16.16
  logic signed [63:0] prnd [9];
  logic signed [33:0] rnd_q [9];

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      prnd[n] = (prod_q[n] + 64'sd536870912) >>> 30;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[6]) begin
      for (int n = 0; n < 9; n++) begin
        rnd_q[n] <= prnd[n][33:0];
      end
    end
  end

  // stage 7: row sums and saturation
  localparam logic signed [35:0] CoordMax = 36'sd2147483647;
  localparam logic signed [35:0] CoordMin = -36'sd2147483648;

  logic signed [35:0]       acc [3];
  logic signed [CoordW-1:0] sat [3];
  logic [2:0]               clip;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 36'(rnd_q[3*r]) + 36'(rnd_q[3*r+1]) + 36'(rnd_q[3*r+2]);
      priority if (acc[r] > CoordMax) begin
        sat[r]  = CoordMax[CoordW-1:0];
        clip[r] = 1'b1;
      end else if (acc[r] < CoordMin) begin
        sat[r]  = CoordMin[CoordW-1:0];
        clip[r] = 1'b1;
      end else begin
        sat[r]  = acc[r][CoordW-1:0];
        clip[r] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[7]) begin
      out_data_o.out_x     <= sat[0];
      out_data_o.out_y     <= sat[1];
      out_data_o.out_z     <= sat[2];
      out_data_o.saturated <= |clip;
    end
  end

  // an accepted transaction always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> valid_q[1])
    else $error("accepted transaction not captured");

  // an empty pipeline never holds off the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q == '0 |-> !in_stall_o)
    else $error("stall raised while pipeline empty");

  // the flag only goes with a component at a bound
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |->
      out_data_o.out_x == 32'sh7fffffff || out_data_o.out_x == 32'sh80000000 ||
      out_data_o.out_y == 32'sh7fffffff || out_data_o.out_y == 32'sh80000000 ||
      out_data_o.out_z == 32'sh7fffffff || out_data_o.out_z == 32'sh80000000)
    else $error("saturated flag without clipped component");

  // a full stage that cannot move keeps its transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[4] && !ready[4] |=> valid_q[4])
    else $error("transaction dropped in stage 4");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams vectors and Euler angles into the rotation block with random gaps
// on both sides and one long output hold-off. Each result is checked, field by
// field, against a bit-exact rotation computed here from its own sine table.
// ----------------------------------------------------------------------------
module tb_top;
  import evr_pkg::*;

  localparam int unsigned TabDepth = 1024;
  localparam int unsigned NumRandom = 1400;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_stall_o;
  evr_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_stall_i;
  evr_out_t out_data_o;

  longint   sine_rom [0:TabDepth];
  evr_in_t  pending_vecs [$];
  evr_out_t rotated_exp [$];
  int       mismatch_cnt = 0;
  int       send_gap;
  int       hold_left;
  int       rx_count;
  bit       hold_done;

  euler_vector_rotation #(.TRIG_TABLE_DEPTH(TabDepth)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // clock
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // quarter-wave sine table, Q1.15, integer Taylor series in Q30
  function automatic void build_sine_rom();
    longint unsigned x, x2, term;
    longint          acc, q;
    for (int i = 0; i <= TabDepth; i++) begin
      x    = (longint'(i) * HALF_PI_Q30 + TabDepth / 2) / TabDepth;
      x2   = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      acc  = x;
      for (int k = 1; term != 0 && k < 40; k++) begin
        term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
        if (k % 2) acc -= term;
        else acc += term;
      end
      if (acc < 0) acc = 0;
      q = (acc + 16384) >>> 15;
      if (q > 32767) q = 32767;
      sine_rom[i] = q;
    end
  endfunction

  // sine of a binary angle, quadrant folded onto the table
  function automatic longint sine_of(int unsigned ang);
    int unsigned u, quad;
    longint      idx, mag;
    u    = ang & 32'hFFFF;
    quad = (u >> 14) & 3;
    idx  = (longint'(u & 32'h3FFF) * TabDepth) >> 14;
    if (idx > TabDepth) idx = TabDepth;
    mag  = (quad & 1) ? sine_rom[TabDepth - idx] : sine_rom[idx];
    return (quad & 2) ? -mag : mag;
  endfunction

  // Q45 entry to Q30, round half up, clamped to +-1.0
  function automatic longint q45_to_q30(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > (64'sd1 <<< 30)) r = 64'sd1 <<< 30;
    if (r < -(64'sd1 <<< 30)) r = -(64'sd1 <<< 30);
    return r;
  endfunction

  // Q16.16 coordinate times Q30 entry, round half up back to Q16.16
  function automatic longint scale_q30(longint v, longint r);
    return (v * r + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic evr_out_t rotate_vec(evr_in_t t);
    longint   v [3];
    longint   sy, cy, sp, cp, sr, cr, acc, hi, lo;
    longint   m [3][3];
    evr_out_t r;
    bit       clip;
    v[0] = t.vec_x;
    v[1] = t.vec_y;
    v[2] = t.vec_z;
    sy = sine_of(int'($unsigned(t.angle_yaw)));
    cy = sine_of(int'($unsigned(t.angle_yaw)) + 16384);
    sp = sine_of(int'($unsigned(t.angle_pitch)));
    cp = sine_of(int'($unsigned(t.angle_pitch)) + 16384);
    sr = sine_of(int'($unsigned(t.angle_roll)));
    cr = sine_of(int'($unsigned(t.angle_roll)) + 16384);
    m[0][0] = cy * cp;
    m[0][1] = q45_to_q30(cy * sp * sr - sy * cr * 32768);
    m[0][2] = q45_to_q30(cy * sp * cr + sy * sr * 32768);
    m[1][0] = sy * cp;
    m[1][1] = q45_to_q30(sy * sp * sr + cy * cr * 32768);
    m[1][2] = q45_to_q30(sy * sp * cr - cy * sr * 32768);
    m[2][0] = -sp * 32768;
    m[2][1] = cp * sr;
    m[2][2] = cp * cr;
    hi   = (64'sd1 <<< (CoordW - 1)) - 1;
    lo   = -hi - 1;
    clip = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = scale_q30(v[0], m[row][0]) + scale_q30(v[1], m[row][1])
          + scale_q30(v[2], m[row][2]);
      if (acc > hi) begin
        acc  = hi;
        clip = 1'b1;
      end
      if (acc < lo) begin
        acc  = lo;
        clip = 1'b1;
      end
      if (row == 0) r.out_x = acc[CoordW-1:0];
      else if (row == 1) r.out_y = acc[CoordW-1:0];
      else r.out_z = acc[CoordW-1:0];
    end
    r.saturated = clip;
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %0s: got %0d, expected %0d at %0t", field, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // idle length: mostly none or short, now and then long
  function automatic int pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [CoordW-1:0] rand_coord();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
    if (r < 9) return $urandom;
    return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  function automatic evr_in_t make_vec(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                                       logic signed [CoordW-1:0] z, logic signed [15:0] yaw,
                                       logic signed [15:0] pitch, logic signed [15:0] roll);
    evr_in_t t;
    t.vec_x = x; t.vec_y = y; t.vec_z = z;
    t.angle_yaw = yaw; t.angle_pitch = pitch; t.angle_roll = roll;
    return t;
  endfunction

  // driver: offers queued transactions, holds a stalled payload steady
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   <= 0;
    end else if (!(in_valid_i && in_stall_o)) begin
      if (in_valid_i) rotated_exp.push_back(rotate_vec(in_data_i));
      if (send_gap != 0) begin
        in_valid_i <= 1'b0;
        send_gap   <= send_gap - 1;
      end else if (pending_vecs.size() != 0) begin
        in_data_i  <= pending_vecs.pop_front();
        in_valid_i <= 1'b1;
        send_gap   <= pick_idle();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver hold-off: random stretches, one long hold after 300 results
  always @(posedge clk_i or negedge rst_ni) begin
    int stall_len;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && rx_count >= 300) begin
      out_stall_i <= 1'b1;
      hold_left   <= 200;
      hold_done   <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_len = pick_idle();
      if (stall_len != 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= stall_len - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // monitor: result checks
  always @(posedge clk_i or negedge rst_ni) begin
    evr_out_t want;
    if (!rst_ni) begin
      rx_count <= 0;
    end else if (out_valid_o && !out_stall_i) begin
      rx_count <= rx_count + 1;
      if (rotated_exp.size() == 0) begin
        $display("unexpected result transaction at %0t", $realtime);
        mismatch_cnt++;
      end else begin
        want = rotated_exp.pop_front();
        if (out_data_o.out_x !== want.out_x) report_mismatch("out_x", out_data_o.out_x, want.out_x);
        if (out_data_o.out_y !== want.out_y) report_mismatch("out_y", out_data_o.out_y, want.out_y);
        if (out_data_o.out_z !== want.out_z) report_mismatch("out_z", out_data_o.out_z, want.out_z);
        if (out_data_o.saturated !== want.saturated)
          report_mismatch("saturated", out_data_o.saturated, want.saturated);
      end
    end
  end

  // stimulus and end of run
  initial begin
    logic signed [15:0] a;
    build_sine_rom();
    rst_ni = 1'b0;

    // directed: zero rotation, angle extremes and quadrant edges, saturation
    pending_vecs.push_back(make_vec(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                    16'sh0000, 16'sh0000, 16'sh0000));
    pending_vecs.push_back(make_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                    16'sh0000, 16'sh0000, 16'sh0000));
    pending_vecs.push_back(make_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    16'sh0000, 16'sh0000, 16'sh0000));
    pending_vecs.push_back(make_vec(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                                    16'sh2000, 16'sh2000, 16'sh2000));
    pending_vecs.push_back(make_vec(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                                    16'shE000, 16'sh2000, 16'shE000));
    pending_vecs.push_back(make_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                                    16'sh8000, 16'sh8000, 16'sh8000));
    a = 16'sh4000;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0: a = 16'sh4000;
        1: a = 16'shC000;
        2: a = 16'sh7FFF;
        3: a = 16'sh8000;
        4: a = 16'sh3FFF;
        default: a = 16'shFFFF;
      endcase
      pending_vecs.push_back(make_vec(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                      a, 16'sh0000, 16'sh0000));
      pending_vecs.push_back(make_vec(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                      16'sh0000, a, 16'sh0000));
      pending_vecs.push_back(make_vec(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                                      16'sh0000, 16'sh0000, a));
    end

    // random: mostly moderate vectors, some full range and bounds
    for (int i = 0; i < NumRandom; i++)
      pending_vecs.push_back(make_vec(rand_coord(), rand_coord(), rand_coord(),
                                      16'($urandom), 16'($urandom), 16'($urandom)));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_vecs.size() == 0 && !in_valid_i && rotated_exp.size() == 0);
    repeat (30) @(posedge clk_i);
    if (mismatch_cnt == 0 && rotated_exp.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: euler_vector_rotation.f
rtl/evr_pkg.sv
rtl/euler_vector_rotation.sv
bench/tb_top.sv
